// File: hdl/assert_macros.svh
// Assertion macros shared by the envelope generator RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds in a cycle -> consequent holds in that same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/evg_pkg.sv
// Shared types, codes and helpers of the envelope generator.
// No dependencies; used by evg_div, eight_stage_envelope_generator and its testbench.
`default_nettype none

package evg_pkg;

    localparam int LEVEL_W     = 16;   // table level and output sample
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 3;
    localparam int CFG_W       = 4;    // sustain / release stage registers
    localparam int STAGE_OUT_W = 4;
    localparam int ACC_W       = 32;
    localparam int SLOPE_W     = 32;
    localparam int DIVIDEND_W  = LEVEL_W + 1;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;  // stage 8: none / no jump

    // request kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd3;

    // register indexes (byte address 4*index)
    localparam logic REG_SUSTAIN = 1'b0;
    localparam logic REG_RELEASE = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TICK = 6'b000010,
        S_RD_A = 6'b000100,
        S_RD_B = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // Clamp the 32-bit accumulator to the signed 16-bit sample range.
    function automatic logic signed [LEVEL_W-1:0] sat_level(input logic [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic signed [LEVEL_W-1:0] res;
        v = signed'(acc);
        if (v > 32'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = signed'(acc[LEVEL_W-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/evg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module evg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/evg_div.sv
// Iterative restoring divider for the stage slope: signed 17-bit difference over
// an unsigned length, truncated toward zero, one quotient bit per cycle. Uses evg_pkg.
`default_nettype none
`include "assert_macros.svh"

module evg_div #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [evg_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [LENGTH_BITS-1:0]        i_divisor,
    output logic                                      o_done,
    output logic             [evg_pkg::SLOPE_W-1:0]   o_quotient
);

    localparam int DW = evg_pkg::DIVIDEND_W;
    localparam int QW = evg_pkg::SLOPE_W;
    localparam int CW = $clog2(DW);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic                   r_neg;
    logic [DW-1:0]          r_quo;
    logic [LENGTH_BITS:0]   r_rem;
    logic [LENGTH_BITS-1:0] r_div;

    logic [DW-1:0]          w_mag;
    logic [LENGTH_BITS:0]   w_rem_sh;
    logic                   w_ge;
    logic [LENGTH_BITS:0]   w_rem_nx;

    assign w_mag    = i_dividend[DW-1] ? (~i_dividend + 1'b1) : i_dividend;
    // remainder stays below the divisor, so its top bit is free for the shift
    assign w_rem_sh = {r_rem[LENGTH_BITS-1:0], r_quo[DW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~QW'(r_quo) + 1'b1) : QW'(r_quo);

    `ASSERT_IMPLIES(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)
    `ASSERT_NEXT(a_done_one_cycle, i_clk, i_rst_n, r_done && !i_start, !r_done)
    `ASSERT_IMPLIES(a_busy_not_done, i_clk, i_rst_n, r_busy, !r_done)

endmodule

`default_nettype wire

// File: hdl/eight_stage_envelope_generator.sv
// Top level of the eight-stage linear envelope generator.
// Uses evg_pkg, evg_ram (level/length table) and evg_div (slope divider).
//
//   channel   direction  handshake                  payload
//   in        request    i_in_valid / o_in_ready    i_kind, i_entry_index, i_entry_level,
//                                                   i_entry_length
//   out       result     o_out_valid / i_out_ready  o_envelope_level, o_stage_now, o_finished
//   config    APB write  psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One request at a time. A load writes the table from idle; a tick that stays in its stage
// passes the tick and output states. A trigger, jumping release or stage change to a slope
// reads the stage's entry and, unless that stage is last or of zero length, the next entry
// from the single-read-port RAM, then runs the 17-step slope divider.
// Reset is synchronous; the table holds no reset value and needs no clearing pass.
// A result waiting in the output register does not block acceptance of the next request;
// the sequencer only stalls when it must place a new result over an untaken one.
`default_nettype none
`include "assert_macros.svh"

module eight_stage_envelope_generator #(
    parameter int NUM_STAGES  = 8,
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // request channel
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic        [evg_pkg::KIND_W-1:0]       i_kind,
    input  wire logic        [evg_pkg::INDEX_W-1:0]      i_entry_index,
    input  wire logic signed [evg_pkg::LEVEL_W-1:0]      i_entry_level,
    input  wire logic        [LENGTH_BITS-1:0]           i_entry_length,
    // result channel
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic signed      [evg_pkg::LEVEL_W-1:0]      o_envelope_level,
    output logic             [evg_pkg::STAGE_OUT_W-1:0]  o_stage_now,
    output logic                                         o_finished,
    // configuration port
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic        [evg_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic        [evg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic             [evg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                         pready
);

    localparam int LW    = evg_pkg::LEVEL_W;
    localparam int ACCW  = evg_pkg::ACC_W;
    localparam int SLW   = evg_pkg::SLOPE_W;
    localparam int CFGW  = evg_pkg::CFG_W;
    localparam int OSTW  = evg_pkg::STAGE_OUT_W;
    localparam int DVW   = evg_pkg::DIVIDEND_W;
    localparam int PDW   = evg_pkg::APB_DATA_W;
    localparam int STW   = $clog2(NUM_STAGES + 1);
    localparam int AW    = $clog2(NUM_STAGES);
    localparam int ENTW  = LW + LENGTH_BITS;

    evg_pkg::t_state r_state, n_state;

    logic [STW-1:0]         r_stage, n_stage;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [ACCW-1:0]        r_acc, n_acc;
    logic [SLW-1:0]         r_slope, n_slope;
    logic                   r_released, n_released;
    logic                   r_running, n_running;
    logic [CFGW-1:0]        r_sustain, r_release;
    logic [AW-1:0]          r_st, n_st;          // stage whose slope is being set
    logic                   r_set_acc, n_set_acc;
    logic                   r_from_tick, n_from_tick;
    logic                   r_out_valid, n_out_valid;

    // payload registers
    logic [LENGTH_BITS-1:0] r_len_a, n_len_a;
    logic [LW-1:0]          r_lvl_a, n_lvl_a;
    logic signed [LW-1:0]   r_out_level;
    logic [OSTW-1:0]        r_out_stage;
    logic                   r_out_finished;

    logic                   w_we;
    logic [AW-1:0]          w_raddr;
    logic [ENTW-1:0]        w_rdata;
    logic [LW-1:0]          w_rd_level;
    logic [LENGTH_BITS-1:0] w_rd_len;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SLW-1:0]         w_div_q;
    logic signed [DVW-1:0]  w_diff;
    logic                   w_load_out;
    logic                   w_cfg_wr;
    logic [STW-1:0]         w_stage_inc;
    logic [LENGTH_BITS-1:0] w_count_inc;
    logic [ACCW-1:0]        w_acc_sum;

    evg_ram #(
        .WIDTH (ENTW),
        .DEPTH (NUM_STAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_entry_level, i_entry_length}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_level = w_rdata[LENGTH_BITS +: LW];
    assign w_rd_len   = w_rdata[LENGTH_BITS-1:0];
    assign w_diff     = signed'({w_rd_level[LW-1], w_rd_level})
                      - signed'({r_lvl_a[LW-1], r_lvl_a});

    evg_div #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff),
        .i_divisor  (r_len_a),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_stage_inc = r_stage + 1'b1;
    assign w_count_inc = r_count + 1'b1;
    assign w_acc_sum   = r_acc + r_slope;

    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        n_count     = r_count;
        n_acc       = r_acc;
        n_slope     = r_slope;
        n_released  = r_released;
        n_running   = r_running;
        n_st        = r_st;
        n_set_acc   = r_set_acc;
        n_from_tick = r_from_tick;
        n_len_a     = r_len_a;
        n_lvl_a     = r_lvl_a;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_raddr     = r_st;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;

        unique case (r_state)
            evg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        evg_pkg::KIND_LOAD: begin
                            w_we = (32'(i_entry_index) < NUM_STAGES);
                        end
                        evg_pkg::KIND_TRIGGER: begin
                            n_stage     = '0;
                            n_count     = '0;
                            n_released  = 1'b0;
                            n_running   = 1'b1;
                            n_st        = '0;
                            n_set_acc   = 1'b1;
                            n_from_tick = 1'b0;
                            w_raddr     = '0;
                            n_state     = evg_pkg::S_RD_A;
                        end
                        evg_pkg::KIND_RELEASE: begin
                            n_released = 1'b1;
                            if (32'(r_release) < NUM_STAGES) begin
                                n_stage     = STW'(r_release);
                                n_count     = '0;
                                n_st        = AW'(r_release);
                                n_set_acc   = 1'b0;
                                n_from_tick = 1'b0;
                                w_raddr     = AW'(r_release);
                                n_state     = evg_pkg::S_RD_A;
                            end
                        end
                        evg_pkg::KIND_TICK: begin
                            if (r_running && (32'(r_stage) < NUM_STAGES)) begin
                                w_raddr = AW'(r_stage);
                                n_state = evg_pkg::S_TICK;
                            end else begin
                                n_state = evg_pkg::S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            evg_pkg::S_TICK: begin
                n_acc   = w_acc_sum;
                n_count = w_count_inc;
                n_state = evg_pkg::S_OUT;
                if (w_count_inc >= w_rd_len) begin
                    n_stage = w_stage_inc;
                    n_count = '0;
                    if (32'(w_stage_inc) >= NUM_STAGES) begin
                        // past the last stage: hold its table level
                        n_acc = ACCW'(signed'(w_rd_level));
                    end else if (!r_released && (32'(w_stage_inc) == 32'(r_sustain))) begin
                        n_slope = '0;
                    end else begin
                        n_st        = AW'(w_stage_inc);
                        n_set_acc   = 1'b0;
                        n_from_tick = 1'b1;
                        w_raddr     = AW'(w_stage_inc);
                        n_state     = evg_pkg::S_RD_A;
                    end
                end
            end
            evg_pkg::S_RD_A: begin
                n_len_a = w_rd_len;
                n_lvl_a = w_rd_level;
                if (r_set_acc) begin
                    n_acc = ACCW'(signed'(w_rd_level));
                end
                if ((32'(r_st) + 32'd1) >= NUM_STAGES) begin
                    // last stage keeps the slope it had
                    n_state = r_from_tick ? evg_pkg::S_OUT : evg_pkg::S_IDLE;
                end else if (w_rd_len == '0) begin
                    n_slope = '0;
                    n_state = r_from_tick ? evg_pkg::S_OUT : evg_pkg::S_IDLE;
                end else begin
                    w_raddr = AW'(32'(r_st) + 32'd1);
                    n_state = evg_pkg::S_RD_B;
                end
            end
            evg_pkg::S_RD_B: begin
                w_div_start = 1'b1;
                n_state     = evg_pkg::S_DIV;
            end
            evg_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_slope = w_div_q;
                    n_state = r_from_tick ? evg_pkg::S_OUT : evg_pkg::S_IDLE;
                end
            end
            evg_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = evg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = evg_pkg::S_IDLE;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= evg_pkg::S_IDLE;
            r_stage     <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_slope     <= '0;
            r_released  <= 1'b0;
            r_running   <= 1'b0;
            r_st        <= '0;
            r_set_acc   <= 1'b0;
            r_from_tick <= 1'b0;
            r_out_valid <= 1'b0;
            r_sustain   <= evg_pkg::CFG_RESET;
            r_release   <= evg_pkg::CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_slope     <= n_slope;
            r_released  <= n_released;
            r_running   <= n_running;
            r_st        <= n_st;
            r_set_acc   <= n_set_acc;
            r_from_tick <= n_from_tick;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    evg_pkg::REG_SUSTAIN: r_sustain <= pwdata[CFGW-1:0];
                    evg_pkg::REG_RELEASE: r_release <= pwdata[CFGW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_a <= n_len_a;
        r_lvl_a <= n_lvl_a;
        if (w_load_out) begin
            r_out_level    <= r_running ? evg_pkg::sat_level(r_acc) : '0;
            r_out_stage    <= OSTW'(r_stage);
            r_out_finished <= (32'(r_stage) >= NUM_STAGES);
        end
    end

    always_comb begin
        unique case (paddr[2])
            evg_pkg::REG_SUSTAIN: prdata = PDW'(r_sustain);
            evg_pkg::REG_RELEASE: prdata = PDW'(r_release);
            default:              prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_in_ready       = (r_state == evg_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_envelope_level = r_out_level;
    assign o_stage_now      = r_out_stage;
    assign o_finished       = r_out_finished;

    `ASSERT_IMPLIES(a_stage_range, i_clk, i_rst_n, 1'b1, 32'(r_stage) <= NUM_STAGES)
    `ASSERT_IMPLIES(a_done_count_clear, i_clk, i_rst_n,
                    32'(r_stage) == NUM_STAGES, r_count == '0)
    `ASSERT_IMPLIES(a_rd_b_after_rd_a, i_clk, i_rst_n,
                    r_state == evg_pkg::S_RD_B, $past(r_state) == evg_pkg::S_RD_A)
    `ASSERT_IMPLIES(a_div_exit_on_done, i_clk, i_rst_n,
                    r_state == evg_pkg::S_DIV && n_state != evg_pkg::S_DIV, w_div_done)
    `ASSERT_IMPLIES(a_write_only_idle, i_clk, i_rst_n,
                    w_we, r_state == evg_pkg::S_IDLE && !w_div_done)

endmodule

`default_nettype wire

// File: verif/eight_stage_envelope_generator_tb.sv
// Self-checking testbench for eight_stage_envelope_generator: directed and random requests,
// a cycle-free envelope predictor and field-by-field checking of every tick sample.
// Depends on evg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module eight_stage_envelope_generator_tb;

    localparam int NUM_ST        = 8;
    localparam int LEN_W         = 24;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PHASE_REQS    = 30;

    typedef struct {
        logic [evg_pkg::KIND_W-1:0]         kind;
        logic [evg_pkg::INDEX_W-1:0]        idx;
        logic signed [evg_pkg::LEVEL_W-1:0] lvl;
        logic [LEN_W-1:0]                   len;
    } t_env_req;

    typedef struct {
        logic signed [evg_pkg::LEVEL_W-1:0] level;
        logic [evg_pkg::STAGE_OUT_W-1:0]    stage;
        logic                               done;
    } t_env_sample;

    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_in_valid     = 1'b0;
    logic                               o_in_ready;
    logic [evg_pkg::KIND_W-1:0]         i_kind         = evg_pkg::KIND_TICK;
    logic [evg_pkg::INDEX_W-1:0]        i_entry_index  = '0;
    logic signed [evg_pkg::LEVEL_W-1:0] i_entry_level  = '0;
    logic [LEN_W-1:0]                   i_entry_length = '0;
    logic                               o_out_valid;
    logic                               i_out_ready    = 1'b0;
    logic signed [evg_pkg::LEVEL_W-1:0] o_envelope_level;
    logic [evg_pkg::STAGE_OUT_W-1:0]    o_stage_now;
    logic                               o_finished;
    logic                               psel           = 1'b0;
    logic                               penable        = 1'b0;
    logic                               pwrite         = 1'b0;
    logic [evg_pkg::APB_ADDR_W-1:0]     paddr          = '0;
    logic [evg_pkg::APB_DATA_W-1:0]     pwdata         = '0;
    logic [evg_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    eight_stage_envelope_generator #(
        .NUM_STAGES  (NUM_ST),
        .LENGTH_BITS (LEN_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_entry_index    (i_entry_index),
        .i_entry_level    (i_entry_level),
        .i_entry_length   (i_entry_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_envelope_level (o_envelope_level),
        .o_stage_now      (o_stage_now),
        .o_finished       (o_finished),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [evg_pkg::LEVEL_W-1:0] env_levels [NUM_ST];
    logic [LEN_W-1:0]                   env_lengths [NUM_ST];
    logic [evg_pkg::CFG_W-1:0]          env_stage    = '0;
    logic [LEN_W-1:0]                   env_ticks    = '0;
    logic [evg_pkg::ACC_W-1:0]          env_acc      = '0;
    logic [evg_pkg::SLOPE_W-1:0]        env_slope    = '0;
    bit                                 env_released = 1'b0;
    bit                                 env_running  = 1'b0;
    logic [evg_pkg::CFG_W-1:0]          sustain_at   = evg_pkg::CFG_RESET;
    logic [evg_pkg::CFG_W-1:0]          release_to   = evg_pkg::CFG_RESET;

    t_env_req    pending_reqs[$];
    t_env_sample expected_samples[$];
    int          queued_reqs = 0;
    int          err_count   = 0;

    t_env_req    launch;
    t_env_req    taken;
    t_env_sample want;
    int          in_gap      = 0;
    bit          in_burst    = 1'b0;
    int          out_stall   = 0;
    int          mon_gap     = 0;
    bit          out_burst   = 1'b0;
    int          idle_cycles = 0;

    function automatic logic signed [evg_pkg::LEVEL_W-1:0] clamp16(
        input logic [evg_pkg::ACC_W-1:0] acc);
        int v;
        v = acc;
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return acc[evg_pkg::LEVEL_W-1:0];
    endfunction

    // The last stage has no next level, so it keeps whatever slope it came in with.
    function automatic void update_slope(input logic [evg_pkg::CFG_W-1:0] st);
        longint rise;
        longint span;
        if (int'(st) + 1 >= NUM_ST) return;
        if (env_lengths[st] == '0) begin
            env_slope = '0;
            return;
        end
        rise = longint'(env_levels[st + 1]) - longint'(env_levels[st]);
        span = longint'(env_lengths[st]);
        env_slope = evg_pkg::SLOPE_W'(rise / span);
    endfunction

    function automatic void advance_envelope(input t_env_req r);
        t_env_sample s;
        case (r.kind)
            evg_pkg::KIND_LOAD: begin
                env_levels[r.idx]  = r.lvl;
                env_lengths[r.idx] = r.len;
            end
            evg_pkg::KIND_TRIGGER: begin
                env_stage    = '0;
                env_ticks    = '0;
                env_acc      = {{(evg_pkg::ACC_W-evg_pkg::LEVEL_W){env_levels[0][evg_pkg::LEVEL_W-1]}},
                                env_levels[0]};
                env_released = 1'b1 == 1'b0;
                env_running  = 1'b1;
                update_slope('0);
            end
            evg_pkg::KIND_RELEASE: begin
                env_released = 1'b1;
                if (release_to < NUM_ST) begin
                    env_stage = release_to;
                    env_ticks = '0;
                    update_slope(env_stage);
                end
            end
            evg_pkg::KIND_TICK: begin
                if (!env_running) begin
                    s.level = '0;
                end else if (env_stage >= NUM_ST) begin
                    s.level = clamp16(env_acc);
                end else begin
                    env_acc   = env_acc + env_slope;
                    env_ticks = env_ticks + 1'b1;
                    if (env_ticks >= env_lengths[env_stage]) begin
                        env_stage = env_stage + 1'b1;
                        env_ticks = '0;
                        if (env_stage >= NUM_ST) begin
                            env_acc = {{(evg_pkg::ACC_W-evg_pkg::LEVEL_W)
                                        {env_levels[NUM_ST-1][evg_pkg::LEVEL_W-1]}},
                                       env_levels[NUM_ST-1]};
                        end else if (!env_released && env_stage == sustain_at) begin
                            env_slope = '0;
                        end else begin
                            update_slope(env_stage);
                        end
                    end
                    s.level = clamp16(env_acc);
                end
                s.stage = env_stage;
                s.done  = (env_stage >= NUM_ST);
                expected_samples.push_back(s);
            end
        endcase
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return LEN_W'($urandom);
        if (r == 1) return '1;
        return LEN_W'($urandom_range(0, 6));
    endfunction

    function automatic void push_req(input logic [evg_pkg::KIND_W-1:0] kind,
                                     input logic [evg_pkg::INDEX_W-1:0] idx,
                                     input logic signed [evg_pkg::LEVEL_W-1:0] lvl,
                                     input logic [LEN_W-1:0] len);
        t_env_req r;
        r.kind = kind;
        r.idx  = idx;
        r.lvl  = lvl;
        r.len  = len;
        pending_reqs.push_back(r);
        queued_reqs++;
    endfunction

    function automatic void push_random(input logic [evg_pkg::KIND_W-1:0] kind);
        push_req(kind, evg_pkg::INDEX_W'($urandom_range(0, 7)),
                 evg_pkg::LEVEL_W'($urandom_range(0, 65535)), rand_length());
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic write_reg(input logic idx, input logic [evg_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= evg_pkg::APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == evg_pkg::REG_SUSTAIN) sustain_at = val;
        else release_to = val;
        @(negedge i_clk);
    endtask

    // Wait for every sample, then give a trailing trigger or release time to finish.
    task automatic settle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly whole notes (reload, trigger, ticks, release, ticks); the rest is noise.
    task automatic play_notes(input int budget);
        int first;
        int r;
        first = queued_reqs;
        while (queued_reqs - first < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                repeat ($urandom_range(0, 3)) push_random(evg_pkg::KIND_LOAD);
                push_random(evg_pkg::KIND_TRIGGER);
                repeat ($urandom_range(1, 24)) push_random(evg_pkg::KIND_TICK);
                if ($urandom_range(0, 3) != 0) push_random(evg_pkg::KIND_RELEASE);
                repeat ($urandom_range(1, 30)) push_random(evg_pkg::KIND_TICK);
            end else if (r < 85) begin
                push_random($urandom_range(0, 1) ? evg_pkg::KIND_RELEASE
                                                 : evg_pkg::KIND_TRIGGER);
                repeat ($urandom_range(1, 6)) push_random(evg_pkg::KIND_TICK);
            end else begin
                push_random(evg_pkg::KIND_W'($urandom_range(0, 3)));
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                taken.kind = i_kind;
                taken.idx  = i_entry_index;
                taken.lvl  = i_entry_level;
                taken.len  = i_entry_length;
                advance_envelope(taken);
            end
            // hold valid and payload while a request waits
            if (!i_in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    launch = pending_reqs.pop_front();
                    i_kind         <= launch.kind;
                    i_entry_index  <= launch.idx;
                    i_entry_level  <= launch.lvl;
                    i_entry_length <= launch.len;
                    i_in_valid     <= 1'b1;
                    in_gap         <= pick_gap(in_burst);
                    if ($urandom_range(0, 49) == 0) in_burst <= !in_burst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample level %0d stage %0d finished %0b",
                                          o_envelope_level, o_stage_now, o_finished));
            end else begin
                want = expected_samples.pop_front();
                if (o_envelope_level !== want.level)
                    report_mismatch($sformatf("envelope_level got %0d want %0d",
                                              o_envelope_level, want.level));
                if (o_stage_now !== want.stage)
                    report_mismatch($sformatf("stage_now got %0d want %0d",
                                              o_stage_now, want.stage));
                if (o_finished !== want.done)
                    report_mismatch($sformatf("finished got %0b want %0b",
                                              o_finished, want.done));
            end
            mon_gap = pick_gap(out_burst);
            if ($urandom_range(0, 49) == 0) out_burst <= !out_burst;
            out_stall   <= mon_gap;
            i_out_ready <= (mon_gap == 0);
        end else if (out_stall != 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= (out_stall == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    logic [evg_pkg::CFG_W-1:0] sustain_plan [8] = '{4'd2, 4'd0, 4'd7, 4'd8,
                                                    4'd4, 4'd3, 4'd8, 4'd6};
    logic [evg_pkg::CFG_W-1:0] release_plan [8] = '{4'd5, 4'd0, 4'd7, 4'd3,
                                                    4'd8, 4'd1, 4'd8, 4'd2};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // point release somewhere so the release before any trigger really jumps
        write_reg(evg_pkg::REG_RELEASE, 4'd3);

        // fill the whole table first: level and length extremes, zero length at entry 2
        push_req(evg_pkg::KIND_LOAD, 3'd0, 16'sd0, 24'd2);
        push_req(evg_pkg::KIND_LOAD, 3'd1, 16'sd32767, 24'd1);
        push_req(evg_pkg::KIND_LOAD, 3'd2, -16'sd32768, 24'd0);
        push_req(evg_pkg::KIND_LOAD, 3'd3, 16'sd100, 24'd3);
        push_req(evg_pkg::KIND_LOAD, 3'd4, -16'sd1, 24'hFFFFFF);
        push_req(evg_pkg::KIND_LOAD, 3'd5, 16'sd5, 24'd2);
        push_req(evg_pkg::KIND_LOAD, 3'd6, 16'sd20000, 24'd1);
        push_req(evg_pkg::KIND_LOAD, 3'd7, -16'sd300, 24'd4);
        // untriggered tick, release while untriggered, tick still silent
        push_req(evg_pkg::KIND_TICK, 3'd5, 16'sh5555, 24'hAAAAAA);
        push_req(evg_pkg::KIND_RELEASE, 3'd2, -16'sh5556, 24'h555555);
        push_req(evg_pkg::KIND_TICK, 3'd7, 16'sd0, 24'd0);
        push_req(evg_pkg::KIND_TRIGGER, 3'd0, 16'sd0, 24'd0);
        // ramp up, steep drop that saturates low, zero-length stage, then a stuck long stage
        repeat (8) push_req(evg_pkg::KIND_TICK, 3'd0, 16'sd0, 24'd0);
        push_req(evg_pkg::KIND_RELEASE, 3'd0, 16'sd0, 24'd0);
        repeat (3) push_req(evg_pkg::KIND_TICK, 3'd0, 16'sd0, 24'd0);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg(evg_pkg::REG_SUSTAIN, sustain_plan[p]);
            write_reg(evg_pkg::REG_RELEASE, release_plan[p]);
            play_notes(PHASE_REQS);
        end
        settle();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/evg_pkg.sv
hdl/evg_ram.sv
hdl/evg_div.sv
hdl/eight_stage_envelope_generator.sv
verif/eight_stage_envelope_generator_tb.sv
